// File: hdl/bsr_pkg.sv
`timescale 1ns / 1ps

package bsr_pkg;

  // frame geometry: fixed row width and column count, default row count
  localparam int unsigned MAX_COLS         = 64;
  localparam int unsigned MAX_ROWS_DEFAULT = 64;
  localparam int unsigned ROW_W            = 64;

  // width of the bounds arithmetic (coordinate plus side length)
  localparam int unsigned CALC_W = 8;
  // width of the signed row and column walkers
  localparam int unsigned POS_W  = 9;

  // command kinds
  localparam logic [1:0] KIND_SQUARE   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_LINE     = 2'd2;
  localparam logic [1:0] KIND_READ     = 2'd3;

  // triangle leg directions
  localparam logic [1:0] CORNER_LU = 2'd0;
  localparam logic [1:0] CORNER_LD = 2'd1;
  localparam logic [1:0] CORNER_RU = 2'd2;
  localparam logic [1:0] CORNER_RD = 2'd3;

  // result status codes
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // configuration register index (address bit 2)
  localparam logic CFG_IDX_COLS = 1'b0;
  localparam logic CFG_IDX_ROWS = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [5:0] x_end;
    logic [5:0] y_end;
    logic [6:0] side;
    logic [1:0] corner;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [ROW_W-1:0]  row_bits;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic res_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic is_read;
    logic zero_len;
    logic last;
  } dp_stat_t;

  // low n bits set, all bits for n of a full row or more
  function automatic logic [ROW_W-1:0] low_mask(input logic [CALC_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n >= CALC_W'(ROW_W)) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << n[5:0]) - ROW_W'(1);
    end
    return m;
  endfunction

endpackage

// File: hdl/bsr_ctrl.sv
`timescale 1ns / 1ps

module bsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  bsr_pkg::dp_stat_t  stat_i,
  output bsr_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DRAW,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // result register can take a new item
  assign slot_free = !out_valid_q || !out_stall_i;

  // commands per state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.step     = (state_q == ST_DRAW);
    cmd_o.res_load = (state_q == ST_FINISH) && slot_free;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat_i.bad || stat_i.is_read || stat_i.zero_len) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (stat_i.last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/bsr_datapath.sv
`timescale 1ns / 1ps

module bsr_datapath #(
  parameter int unsigned MAX_ROWS = bsr_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsr_pkg::ctl_cmd_t   cmd_i,
  output bsr_pkg::dp_stat_t   stat_o,
  input  bsr_pkg::in_item_t   in_data_i,
  input  logic [6:0]          cols_i,
  input  logic [6:0]          rows_i,
  output bsr_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = bsr_pkg::CALC_W;
  localparam int unsigned PW  = bsr_pkg::POS_W;
  localparam int unsigned RW  = bsr_pkg::ROW_W;

  typedef enum logic [1:0] {
    MM_HOLD,
    MM_SHRINK_LO,
    MM_SHRINK_HI,
    MM_POINT
  } mask_mode_e;

  bsr_pkg::in_item_t  cmd_q;
  bsr_pkg::out_item_t res_q;

  // frame store and per-row valid bits
  logic [RW-1:0]       frame_mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_q;

  // walkers
  logic [PW-1:0] row_q, row_init;
  logic [PW-1:0] col_q, col_init;
  logic          row_dn_q, row_dn_init;
  logic          col_rt_q, col_rt_init;
  logic [RW-1:0] mask_q, mask_init, cur_mask;
  mask_mode_e    mode_q, mode_init;
  logic [6:0]    cnt_q, cnt_init;

  // read and write stages
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [RW-1:0] rd_data_q;
  logic          rd_vld_q;
  logic          wr_en_q;
  logic [AW-1:0] wr_addr_q;
  logic [RW-1:0] wr_mask_q;
  logic          bad_q;

  logic [CW-1:0] xw, yw, xew, yew, sw, ww, hw;
  logic [CW-1:0] lo, hi;
  logic [5:0]    adx, ady;
  logic          left, up, bad, row_ok, col_ok;

  assign xw  = {2'b00, cmd_q.x};
  assign yw  = {2'b00, cmd_q.y};
  assign xew = {2'b00, cmd_q.x_end};
  assign yew = {2'b00, cmd_q.y_end};
  assign sw  = {1'b0, cmd_q.side};
  assign ww  = {1'b0, cols_i};
  assign hw  = {1'b0, rows_i};

  assign left = (cmd_q.corner == bsr_pkg::CORNER_LU) || (cmd_q.corner == bsr_pkg::CORNER_LD);
  assign up   = (cmd_q.corner == bsr_pkg::CORNER_LU) || (cmd_q.corner == bsr_pkg::CORNER_RU);

  // bounds checks
  always_comb begin
    case (cmd_q.kind)
      bsr_pkg::KIND_SQUARE: begin
        bad = (xw + sw > ww) || (yw + sw > hw) || (xw > ww) || (yw > hw);
      end
      bsr_pkg::KIND_TRIANGLE: begin
        bad = (xw >= ww) || (yw >= hw) ||
              (left && (sw > xw + CW'(1))) || (!left && (xw + sw > ww)) ||
              (up && (sw > yw + CW'(1))) || (!up && (yw + sw > hw));
      end
      bsr_pkg::KIND_LINE: begin
        bad = (xw >= ww) || (yw >= hw) || (xew >= ww) || (yew >= hw);
      end
      default: begin
        bad = (yw >= hw);
      end
    endcase
  end

  // walker start values
  always_comb begin
    lo          = '0;
    hi          = '0;
    adx         = (cmd_q.x_end > cmd_q.x) ? cmd_q.x_end - cmd_q.x : cmd_q.x - cmd_q.x_end;
    ady         = (cmd_q.y_end > cmd_q.y) ? cmd_q.y_end - cmd_q.y : cmd_q.y - cmd_q.y_end;
    row_init    = {3'b000, cmd_q.y};
    col_init    = {3'b000, cmd_q.x};
    row_dn_init = 1'b1;
    col_rt_init = 1'b1;
    mask_init   = '0;
    mode_init   = MM_HOLD;
    cnt_init    = cmd_q.side;
    case (cmd_q.kind)
      bsr_pkg::KIND_SQUARE: begin
        mask_init = bsr_pkg::low_mask(xw + sw) & ~bsr_pkg::low_mask(xw);
      end
      bsr_pkg::KIND_TRIANGLE: begin
        row_dn_init = !up;
        if (left) begin
          mask_init = bsr_pkg::low_mask(xw + CW'(1)) &
                      ~bsr_pkg::low_mask(xw + CW'(1) - sw);
          mode_init = MM_SHRINK_LO;
        end else begin
          mask_init = bsr_pkg::low_mask(xw + sw) & ~bsr_pkg::low_mask(xw);
          mode_init = MM_SHRINK_HI;
        end
      end
      bsr_pkg::KIND_LINE: begin
        if (cmd_q.x == cmd_q.x_end) begin
          // vertical run from the upper end point
          lo        = (yw < yew) ? yw : yew;
          row_init  = PW'(lo);
          mask_init = RW'(1) << cmd_q.x;
          cnt_init  = {1'b0, ady} + 7'd1;
        end else if (cmd_q.y == cmd_q.y_end) begin
          // horizontal span in one row
          lo        = (xw < xew) ? xw : xew;
          hi        = (xw < xew) ? xew : xw;
          mask_init = bsr_pkg::low_mask(hi + CW'(1)) & ~bsr_pkg::low_mask(lo);
          cnt_init  = 7'd1;
        end else begin
          // diagonal walk, one pixel per row
          row_dn_init = (cmd_q.y_end > cmd_q.y);
          col_rt_init = (cmd_q.x_end > cmd_q.x);
          mode_init   = MM_POINT;
          cnt_init    = {1'b0, ((adx > ady) ? adx : ady)} + 7'd1;
        end
      end
      default: begin
        cnt_init = '0;
      end
    endcase
  end

  assign stat_o.bad      = bad;
  assign stat_o.is_read  = (cmd_q.kind == bsr_pkg::KIND_READ);
  assign stat_o.zero_len = (cnt_init == 7'd0);
  assign stat_o.last     = (cnt_q == 7'd1);

  // current step
  assign row_ok   = !row_q[PW-1] && (row_q[CW-1:0] < hw);
  assign col_ok   = (mode_q != MM_POINT) || (!col_q[PW-1] && (col_q[CW-1:0] < ww));
  assign cur_mask = (mode_q == MM_POINT) ? (RW'(1) << col_q[5:0]) : mask_q;

  assign rd_en   = (cmd_i.check && stat_o.is_read && !bad) || cmd_i.step;
  assign rd_addr = cmd_i.check ? yw[AW-1:0] : row_q[AW-1:0];

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_data_i;
    end
  end

  // walkers: loaded at the check, advanced once per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      row_q    <= row_init;
      col_q    <= col_init;
      row_dn_q <= row_dn_init;
      col_rt_q <= col_rt_init;
      mask_q   <= mask_init;
      mode_q   <= mode_init;
      cnt_q    <= cnt_init;
    end else if (cmd_i.step) begin
      row_q <= row_dn_q ? row_q + PW'(1) : row_q - PW'(1);
      col_q <= col_rt_q ? col_q + PW'(1) : col_q - PW'(1);
      cnt_q <= cnt_q - 7'd1;
      case (mode_q)
        MM_SHRINK_LO: mask_q <= mask_q & (mask_q << 1);
        MM_SHRINK_HI: mask_q <= mask_q & (mask_q >> 1);
        default:      mask_q <= mask_q;
      endcase
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= frame_mem_q[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
    end
  end

  // write stage, in the cycle after the read of the same row
  always_ff @(posedge clk_i) begin
    wr_addr_q <= row_q[AW-1:0];
    wr_mask_q <= cur_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= cmd_i.step && row_ok && col_ok;
    end
  end

  // merge new pixels into the row
  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      frame_mem_q[wr_addr_q] <= (rd_vld_q ? rd_data_q : '0) | wr_mask_q;
    end
  end

  // rows never written read as clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en_q) begin
      row_vld_q[wr_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.check) begin
      bad_q <= bad;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.status <= bad_q ? bsr_pkg::STATUS_RANGE : bsr_pkg::STATUS_DONE;
      if (stat_o.is_read && !bad_q) begin
        res_q.row_bits <= (rd_vld_q ? rd_data_q : '0) & bsr_pkg::low_mask(ww);
      end else begin
        res_q.row_bits <= '0;
      end
    end
  end

  assign out_data_o = res_q;

endmodule

// File: hdl/bitmap_shape_rasterizer_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_stall_o      in_data_i  (bsr_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i    out_data_o (bsr_pkg::out_item_t)
// cfg       input      psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// a read, a reject or an empty shape goes from the check step straight to finish; a drawing
// command first does one read-modify-write per row (side, line height, diagonal length + 1)
// the input reopens the cycle after the result loads
// reset clears the frame at once through per-row valid bits, no clearing pass
// a stalled result holds; the next item waits in the finish step for the slot

module bitmap_shape_rasterizer_top #(
  parameter int unsigned MAX_ROWS = bsr_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsr_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [6:0] cols_q, rows_q;
  logic [6:0] eff_cols, eff_rows;

  bsr_pkg::ctl_cmd_t cmd;
  bsr_pkg::dp_stat_t stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        bsr_pkg::CFG_IDX_COLS: cols_q <= pwdata[6:0];
        bsr_pkg::CFG_IDX_ROWS: rows_q <= pwdata[6:0];
        default:               cols_q <= cols_q;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = {25'd0, (paddr[2] == bsr_pkg::CFG_IDX_ROWS) ? rows_q : cols_q};

  // board size clamped to what the frame holds, zero taken as one
  always_comb begin
    if (cols_q == 7'd0) begin
      eff_cols = 7'd1;
    end else if ({2'b00, cols_q} > 9'(bsr_pkg::MAX_COLS)) begin
      eff_cols = 7'(bsr_pkg::MAX_COLS);
    end else begin
      eff_cols = cols_q;
    end
    if (rows_q == 7'd0) begin
      eff_rows = 7'd1;
    end else if ({2'b00, rows_q} > 9'(MAX_ROWS)) begin
      eff_rows = 7'(MAX_ROWS);
    end else begin
      eff_rows = rows_q;
    end
  end

  bsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bsr_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .cols_i     (eff_cols),
    .rows_i     (eff_rows),
    .out_data_o (out_data_o)
  );

endmodule

// File: tb/sv/raster_checker.sv
`timescale 1ns / 1ps

module raster_checker
  import bsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          errors_o,
  output int          pending_o
);

  // shadow frame and board size
  logic [ROW_W-1:0] frame [MAX_ROWS_DEFAULT];
  logic [6:0]       cols_reg;
  logic [6:0]       rows_reg;
  out_item_t        expected_results [$];
  int               mismatch_count = 0;

  // register value clamped to the usable range
  function automatic int dim_in_use(input logic [6:0] raw, input int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // count columns starting at column first
  function automatic logic [ROW_W-1:0] col_span(input int first, input int count);
    logic [ROW_W-1:0] m;
    if (count <= 0 || first < 0 || first > 63) return '0;
    m = (count >= 64) ? '1 : ((64'd1 << count) - 64'd1);
    return m << first;
  endfunction

  function automatic void paint_span(input int row, input int first, input int count);
    if (row < 0 || row >= MAX_ROWS_DEFAULT) return;
    frame[row] |= col_span(first, count);
  endfunction

  function automatic void paint_pixel(input int row, input int col);
    if (row < 0 || row >= MAX_ROWS_DEFAULT || col < 0 || col > 63) return;
    frame[row][col] = 1'b1;
  endfunction

  // apply one command to the shadow frame and return its result
  function automatic out_item_t rasterize(input in_item_t cmd);
    int w, h, x, y, xe, ye, sd, k, n, lo, hi, sx, sy, adx, ady, len, px, py;
    logic left, up, bad;
    out_item_t res;
    w  = dim_in_use(cols_reg, MAX_COLS);
    h  = dim_in_use(rows_reg, MAX_ROWS_DEFAULT);
    x  = int'(cmd.x);
    y  = int'(cmd.y);
    xe = int'(cmd.x_end);
    ye = int'(cmd.y_end);
    sd = int'(cmd.side);
    bad = 1'b0;
    res.row_bits = '0;
    case (cmd.kind)
      KIND_SQUARE: begin
        if (x + sd > w || y + sd > h) bad = 1'b1;
        else for (k = 0; k < sd; k++) paint_span(y + k, x, sd);
      end
      KIND_TRIANGLE: begin
        left = (cmd.corner == CORNER_LU || cmd.corner == CORNER_LD);
        up   = (cmd.corner == CORNER_LU || cmd.corner == CORNER_RU);
        if (x >= w || y >= h) bad = 1'b1;
        else if (left && sd > x + 1) bad = 1'b1;
        else if (!left && x + sd > w) bad = 1'b1;
        else if (up && sd > y + 1) bad = 1'b1;
        else if (!up && y + sd > h) bad = 1'b1;
        else begin
          // each row away from the vertex loses one pixel
          for (k = 0; k < sd; k++) begin
            n = sd - k;
            paint_span(up ? y - k : y + k, left ? x - n + 1 : x, n);
          end
        end
      end
      KIND_LINE: begin
        if (x >= w || y >= h || xe >= w || ye >= h) begin
          bad = 1'b1;
        end else if (x == xe) begin
          lo = (y < ye) ? y : ye;
          hi = (y < ye) ? ye : y;
          for (k = lo; k <= hi; k++) paint_pixel(k, x);
        end else if (y == ye) begin
          lo = (x < xe) ? x : xe;
          hi = (x < xe) ? xe : x;
          paint_span(y, lo, hi - lo + 1);
        end else begin
          // diagonal walk, pixels off the board are dropped
          sx  = (xe > x) ? 1 : -1;
          sy  = (ye > y) ? 1 : -1;
          adx = (xe > x) ? xe - x : x - xe;
          ady = (ye > y) ? ye - y : y - ye;
          len = (adx > ady) ? adx : ady;
          for (k = 0; k <= len; k++) begin
            px = x + k * sx;
            py = y + k * sy;
            if (px >= 0 && px < w && py >= 0 && py < h) paint_pixel(py, px);
          end
        end
      end
      default: begin
        if (y >= h) bad = 1'b1;
        else res.row_bits = frame[y] & col_span(0, w);
      end
    endcase
    res.status = bad ? STATUS_RANGE : STATUS_DONE;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (frame[r]) frame[r] = '0;
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      expected_results.delete();
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == CFG_IDX_COLS) cols_reg = pwdata_i[6:0];
        else rows_reg = pwdata_i[6:0];
      end
      // compare an accepted result with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result status %0b bits %h",
                     $realtime, out_data_i.status, out_data_i.row_bits);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status || out_data_i.row_bits !== want.row_bits)
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch status exp %0b got %0b, bits exp %h got %h",
                       $realtime, want.status, out_data_i.status,
                       want.row_bits, out_data_i.row_bits);
          end
        end
      end
      // predict each accepted item
      if (in_valid_i && !in_stall_i) expected_results.push_back(rasterize(in_data_i));
    end
    errors_o  <= mismatch_count;
    pending_o <= expected_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsr_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 3000;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int   mismatches;
  int   results_pending;
  logic steady = 1'b0;
  int   quiet_cycles = 0;

  bitmap_shape_rasterizer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  raster_checker raster_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (mismatches),
    .pending_o   (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side stalls at random, except in the steady phase
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 23);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int board_dim(input logic [6:0] raw, input int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic int clamp_coord(input int v, input int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  function automatic int near_coord(input int v, input int lim);
    return clamp_coord(v + $urandom_range(12) - 6, lim);
  endfunction

  // mostly small, sometimes up to the fit, sometimes one too many
  function automatic int shape_size(input int fit);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return fit + 1;
    if (roll < 10) return $urandom_range(fit);
    return $urandom_range((fit < 4) ? fit : 4);
  endfunction

  // mostly in-range commands on a w x h board, the rest raw noise
  function automatic in_item_t random_command(input int w, input int h);
    in_item_t    cmd;
    logic [63:0] raw;
    int          pick, x, y, d, hl, vl;
    logic        left, up;
    raw = {$urandom, $urandom};
    cmd = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(99) < 15) return cmd;
    pick = $urandom_range(99);
    x = $urandom_range(w - 1);
    y = $urandom_range(h - 1);
    cmd.x = 6'(x);
    cmd.y = 6'(y);
    if (pick < 35) begin
      cmd.kind = KIND_READ;
    end else if (pick < 55) begin
      cmd.kind = KIND_SQUARE;
      cmd.side = 7'(shape_size((w - x < h - y) ? w - x : h - y));
    end else if (pick < 75) begin
      cmd.kind = KIND_TRIANGLE;
      left = (cmd.corner == CORNER_LU || cmd.corner == CORNER_LD);
      up   = (cmd.corner == CORNER_LU || cmd.corner == CORNER_RU);
      hl = left ? x + 1 : w - x;
      vl = up ? y + 1 : h - y;
      cmd.side = 7'(shape_size((hl < vl) ? hl : vl));
    end else begin
      cmd.kind = KIND_LINE;
      case ($urandom_range(3))
        0: begin
          cmd.x_end = 6'(x);
          cmd.y_end = 6'(near_coord(y, h));
        end
        1: begin
          cmd.x_end = 6'(near_coord(x, w));
          cmd.y_end = 6'(y);
        end
        2: begin
          d = $urandom_range(1, 6);
          cmd.x_end = 6'(clamp_coord($urandom_range(1) ? x + d : x - d, w));
          cmd.y_end = 6'(clamp_coord($urandom_range(1) ? y + d : y - d, h));
        end
        default: begin
          cmd.x_end = 6'($urandom_range(w - 1));
          cmd.y_end = 6'($urandom_range(h - 1));
        end
      endcase
    end
    return cmd;
  endfunction

  task automatic send_item(input in_item_t cmd);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_cmd(input logic [1:0] kind, input int x, y, xe, ye, sd,
                          input logic [1:0] corner);
    in_item_t cmd;
    cmd.kind   = kind;
    cmd.x      = 6'(x);
    cmd.y      = 6'(y);
    cmd.x_end  = 6'(xe);
    cmd.y_end  = 6'(ye);
    cmd.side   = 7'(sd);
    cmd.corner = corner;
    send_item(cmd);
  endtask

  // hold off until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [6:0] cols_val, rows_val;
    int         w, h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full board after reset: edges of every shape
    send_cmd(KIND_READ,      0,  0,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_SQUARE,    0,  0,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_SQUARE,   60, 60,  0,  0,  4, CORNER_LU);
    send_cmd(KIND_SQUARE,   61,  0,  0,  0,  4, CORNER_LU);
    send_cmd(KIND_SQUARE,    1,  0,  0,  0, 64, CORNER_LU);
    send_cmd(KIND_TRIANGLE,  5,  5,  0,  0,  6, CORNER_LU);
    send_cmd(KIND_TRIANGLE, 10, 20,  0,  0,  3, CORNER_LD);
    send_cmd(KIND_TRIANGLE, 30, 10,  0,  0,  4, CORNER_RU);
    send_cmd(KIND_TRIANGLE, 58, 58,  0,  0,  6, CORNER_RD);
    send_cmd(KIND_TRIANGLE,  2,  5,  0,  0,  4, CORNER_LU);
    send_cmd(KIND_TRIANGLE, 63, 63,  0,  0,  0, CORNER_RD);
    send_cmd(KIND_LINE,     40, 50, 40, 30,  0, CORNER_LU);
    send_cmd(KIND_LINE,     63, 63,  0, 63,  0, CORNER_LU);
    send_cmd(KIND_LINE,     62,  2, 50,  0,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 63,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 60,  0,  0,  0, CORNER_LU);

    // reduced board: rejects, clipping and column masking
    drain();
    write_reg(CFG_IDX_COLS, 7'd40);
    write_reg(CFG_IDX_ROWS, 7'd30);
    send_cmd(KIND_LINE,     10,  5, 50,  5,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 30,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_TRIANGLE, 45,  3,  0,  0,  1, CORNER_RD);
    send_cmd(KIND_SQUARE,   36, 26,  0,  0,  4, CORNER_LU);
    send_cmd(KIND_LINE,      0, 28, 39, 29,  0, CORNER_LU);
    send_cmd(KIND_LINE,     20, 20, 20, 20,  0, CORNER_LU);
    send_cmd(KIND_READ,      0,  1,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 29,  0,  0,  0, CORNER_LU);

    // random phases over a spread of board sizes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols_val = 7'd64;  rows_val = 7'd64;  end
        1: begin cols_val = 7'd1;   rows_val = 7'd1;   end
        2: begin cols_val = 7'd0;   rows_val = 7'd0;   end
        3: begin cols_val = 7'd127; rows_val = 7'd127; end
        4: begin cols_val = 7'd64;  rows_val = 7'd1;   end
        5: begin cols_val = 7'd1;   rows_val = 7'd64;  end
        6: begin cols_val = 7'd33;  rows_val = 7'd17;  end
        9: begin cols_val = 7'd64;  rows_val = 7'd64;  end
        default: begin
          cols_val = 7'($urandom_range(127));
          rows_val = 7'($urandom_range(127));
        end
      endcase
      drain();
      write_reg(CFG_IDX_COLS, cols_val);
      write_reg(CFG_IDX_ROWS, rows_val);
      w = board_dim(cols_val, MAX_COLS);
      h = board_dim(rows_val, MAX_ROWS_DEFAULT);
      steady = (p == 3);
      repeat (ITEMS_PER_PHASE) send_item(random_command(w, h));
      steady = 1'b0;
    end

    // largest square over the whole board, then read it back
    send_cmd(KIND_SQUARE,    0,  0,  0,  0, 64, CORNER_LU);
    send_cmd(KIND_READ,      0,  0,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 31,  0,  0,  0, CORNER_LU);
    send_cmd(KIND_READ,      0, 63,  0,  0,  0, CORNER_LU);

    drain();
    if (mismatches == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
